### rtl/core/ptc_pkg.sv
package ptc_pkg;

   // width of one stored table entry: type, offset, size, flags
   localparam int ENTRY_W = 128;

   // configuration port index width
   localparam int CSR_IDX_W = 3;

   typedef enum logic [1:0] {
      ST_OK      = 2'd0,
      ST_INVALID = 2'd1,
      ST_ARG     = 2'd2,
      ST_SEQ     = 2'd3
   } status_type;

   typedef enum logic [1:0] {
      CMD_HEADER      = 2'd0,
      CMD_ENTRY       = 2'd1,
      CMD_LOOKUP_TYPE = 2'd2,
      CMD_LOOKUP_SLOT = 2'd3
   } cmd_type;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_STORAGE_BYTES    = 3'd0,
      CSR_SECTOR_SHIFT     = 3'd1,
      CSR_EXPECTED_MAGIC   = 3'd2,
      CSR_EXPECTED_VERSION = 3'd3,
      CSR_INVALID_TYPE     = 3'd4,
      CSR_PRIMARY_TYPE     = 3'd5,
      CSR_SECONDARY_TYPE   = 3'd6
   } csr_index_type;

   typedef struct packed {
      logic [31:0] storage_bytes;
      logic [4:0]  sector_shift;
      logic [31:0] expected_magic;
      logic [31:0] expected_version;
      logic [31:0] invalid_type_code;
      logic [31:0] primary_type_code;
      logic [31:0] secondary_type_code;
   } cfg_type;

   localparam cfg_type CFG_RESET = '{
      storage_bytes:       32'd1048576,
      sector_shift:        5'd12,
      expected_magic:      32'd0,
      expected_version:    32'd1,
      invalid_type_code:   32'd0,
      primary_type_code:   32'd1,
      secondary_type_code: 32'd2
   };

endpackage

### rtl/core/ptc_ifs.sv
interface ptc_req_if;
   logic        valid;
   logic        ready;
   logic [1:0]  command;
   logic [31:0] magic_word;
   logic [31:0] version_word;
   logic [31:0] entry_count;
   logic [31:0] part_type;
   logic [31:0] part_offset;
   logic [31:0] part_size;
   logic [31:0] part_flags;
   logic [31:0] slot_id;

   modport source (output valid, command, magic_word, version_word, entry_count,
                   part_type, part_offset, part_size, part_flags, slot_id,
                   input ready);
   modport sink (input valid, command, magic_word, version_word, entry_count,
                 part_type, part_offset, part_size, part_flags, slot_id,
                 output ready);
endinterface

interface ptc_rsp_if;
   logic        valid;
   logic        ready;
   logic [1:0]  status;
   logic [31:0] found_type;
   logic [31:0] found_offset;
   logic [31:0] found_size;
   logic [31:0] found_flags;
   logic        table_complete;

   modport source (output valid, status, found_type, found_offset, found_size,
                   found_flags, table_complete,
                   input ready);
   modport sink (input valid, status, found_type, found_offset, found_size,
                 found_flags, table_complete,
                 output ready);
endinterface

interface ptc_csr_if;
   logic        valid;
   logic        ready;
   logic [2:0]  index;
   logic [31:0] data;

   modport source (output valid, index, data, input ready);
   modport sink (input valid, index, data, output ready);
endinterface

### rtl/core/ptc_ram.sv
module ptc_ram #(
   parameter int WIDTH = 128,
   parameter int DEPTH = 16,
   localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic             clock,
   input  logic             we,
   input  logic [AW-1:0]    waddr,
   input  logic [WIDTH-1:0] wdata,
   input  logic [AW-1:0]    raddr,
   output logic [WIDTH-1:0] rdata
);

   logic [WIDTH-1:0] mem_ff [DEPTH];

   // one write port, one registered read port
   always_ff @(posedge clock) begin
      if (we) begin
         mem_ff[waddr] <= wdata;
      end
      rdata <= mem_ff[raddr];
   end

endmodule

### rtl/core/ptc_seq.sv
module ptc_seq
   import ptc_pkg::*;
#(
   parameter int MAX_ENTRIES = 16,
   localparam int IDX_W = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1,
   localparam int CNT_W = $clog2(MAX_ENTRIES + 1)
) (
   input  logic               clock,
   input  logic               reset,
   input  cfg_type            cfg,
   ptc_req_if.sink            req_chan,
   ptc_rsp_if.source          rsp_chan,
   output logic               ram_we,
   output logic [IDX_W-1:0]   ram_waddr,
   output logic [ENTRY_W-1:0] ram_wdata,
   output logic [IDX_W-1:0]   ram_raddr,
   input  logic [ENTRY_W-1:0] ram_rdata
);

   typedef enum logic [3:0] {
      S_IDLE = 4'b0001,
      S_EVAL = 4'b0010,
      S_SCAN = 4'b0100,
      S_RESP = 4'b1000
   } state_type;

   state_type   state_ff, state_in;

   // latched item
   cmd_type     cmd_ff, cmd_in;
   logic [31:0] magic_ff, magic_in;
   logic [31:0] ver_ff, ver_in;
   logic [31:0] cnt_ff, cnt_in;
   logic [31:0] ty_ff, ty_in;
   logic [31:0] off_ff, off_in;
   logic [31:0] sz_ff, sz_in;
   logic [31:0] fl_ff, fl_in;
   logic [31:0] slot_ff, slot_in;
   logic [31:0] key_ff, key_in;
   logic [32:0] end_ff, end_in;

   // table state
   logic [CNT_W-1:0] ann_ff, ann_in;
   logic [CNT_W-1:0] acc_ff, acc_in;
   logic             hdr_ff, hdr_in;
   logic             fail_ff, fail_in;

   // scan control
   logic [CNT_W-1:0] rd_idx_ff, rd_idx_in;
   logic             pend_ff, pend_in;

   // result register
   status_type  status_ff, status_in;
   logic [31:0] fnd_ty_ff, fnd_ty_in;
   logic [31:0] fnd_off_ff, fnd_off_in;
   logic [31:0] fnd_sz_ff, fnd_sz_in;
   logic [31:0] fnd_fl_ff, fnd_fl_in;

   logic [31:0] mask;
   logic [32:0] end_sum;
   logic        entry_bad;
   logic        entry_seq;
   logic        complete;
   logic [31:0] r_ty, r_off, r_sz, r_fl;
   logic [32:0] r_end;
   logic        overlap;
   logic        hit;

   // entry checks that need no stored data
   assign mask      = ~(32'hFFFF_FFFF << cfg.sector_shift);
   assign end_sum   = {1'b0, off_ff} + {1'b0, sz_ff};
   assign entry_bad = (ty_ff == cfg.invalid_type_code) || ((off_ff & mask) != 32'd0) ||
                      ((sz_ff & mask) != 32'd0) || (sz_ff == 32'd0) ||
                      (end_sum > {1'b0, cfg.storage_bytes});
   assign entry_seq = !hdr_ff || fail_ff || (acc_ff >= ann_ff) ||
                      (acc_ff >= CNT_W'(MAX_ENTRIES));
   assign complete  = hdr_ff && !fail_ff && (acc_ff == ann_ff);

   // shared compare unit on the entry read back from storage
   assign r_ty    = ram_rdata[127:96];
   assign r_off   = ram_rdata[95:64];
   assign r_sz    = ram_rdata[63:32];
   assign r_fl    = ram_rdata[31:0];
   assign r_end   = {1'b0, r_off} + {1'b0, r_sz};
   assign overlap = ({1'b0, off_ff} < r_end) && ({1'b0, r_off} < end_ff);
   assign hit     = (cmd_ff == CMD_ENTRY) ? overlap : (r_ty == key_ff);

   // storage ports
   assign ram_waddr = acc_ff[IDX_W-1:0];
   assign ram_wdata = {ty_ff, off_ff, sz_ff, fl_ff};
   assign ram_raddr = rd_idx_ff[IDX_W-1:0];

   // handshakes
   assign req_chan.ready = (state_ff == S_IDLE);
   assign rsp_chan.valid = (state_ff == S_RESP);
   assign rsp_chan.status         = status_ff;
   assign rsp_chan.found_type     = fnd_ty_ff;
   assign rsp_chan.found_offset   = fnd_off_ff;
   assign rsp_chan.found_size     = fnd_sz_ff;
   assign rsp_chan.found_flags    = fnd_fl_ff;
   assign rsp_chan.table_complete = complete;

   // sequencer
   always_comb begin
      state_in   = state_ff;
      cmd_in     = cmd_ff;
      magic_in   = magic_ff;
      ver_in     = ver_ff;
      cnt_in     = cnt_ff;
      ty_in      = ty_ff;
      off_in     = off_ff;
      sz_in      = sz_ff;
      fl_in      = fl_ff;
      slot_in    = slot_ff;
      key_in     = key_ff;
      end_in     = end_ff;
      ann_in     = ann_ff;
      acc_in     = acc_ff;
      hdr_in     = hdr_ff;
      fail_in    = fail_ff;
      rd_idx_in  = rd_idx_ff;
      pend_in    = pend_ff;
      status_in  = status_ff;
      fnd_ty_in  = fnd_ty_ff;
      fnd_off_in = fnd_off_ff;
      fnd_sz_in  = fnd_sz_ff;
      fnd_fl_in  = fnd_fl_ff;
      ram_we     = 1'b0;

      unique case (state_ff)
         S_IDLE: begin
            if (req_chan.valid) begin
               cmd_in   = cmd_type'(req_chan.command);
               magic_in = req_chan.magic_word;
               ver_in   = req_chan.version_word;
               cnt_in   = req_chan.entry_count;
               ty_in    = req_chan.part_type;
               off_in   = req_chan.part_offset;
               sz_in    = req_chan.part_size;
               fl_in    = req_chan.part_flags;
               slot_in  = req_chan.slot_id;
               state_in = S_EVAL;
            end
         end

         S_EVAL: begin
            fnd_ty_in  = 32'd0;
            fnd_off_in = 32'd0;
            fnd_sz_in  = 32'd0;
            fnd_fl_in  = 32'd0;
            rd_idx_in  = '0;
            pend_in    = 1'b0;
            state_in   = S_RESP;
            unique case (cmd_ff) inside
               CMD_HEADER: begin
                  acc_in = '0;
                  if (cfg.storage_bytes == 32'd0) begin
                     status_in = ST_ARG;
                  end else if ((magic_ff != cfg.expected_magic) ||
                               (ver_ff != cfg.expected_version) ||
                               (cnt_ff > 32'(MAX_ENTRIES))) begin
                     status_in = ST_INVALID;
                  end else begin
                     status_in = ST_OK;
                  end
                  if ((cfg.storage_bytes != 32'd0) && (magic_ff == cfg.expected_magic) &&
                      (ver_ff == cfg.expected_version) &&
                      (cnt_ff <= 32'(MAX_ENTRIES))) begin
                     ann_in  = cnt_ff[CNT_W-1:0];
                     hdr_in  = 1'b1;
                     fail_in = 1'b0;
                  end else begin
                     ann_in  = '0;
                     hdr_in  = 1'b0;
                     fail_in = 1'b1;
                  end
               end
               CMD_ENTRY: begin
                  if (entry_seq) begin
                     status_in = ST_SEQ;
                  end else if (entry_bad) begin
                     status_in = ST_INVALID;
                     fail_in   = 1'b1;
                  end else begin
                     end_in   = end_sum;
                     state_in = S_SCAN;
                  end
               end
               CMD_LOOKUP_TYPE, CMD_LOOKUP_SLOT: begin
                  if (!complete) begin
                     status_in = ST_SEQ;
                  end else if ((cmd_ff == CMD_LOOKUP_SLOT) && (slot_ff > 32'd1)) begin
                     status_in = ST_ARG;
                  end else begin
                     if (cmd_ff == CMD_LOOKUP_SLOT) begin
                        key_in = (slot_ff == 32'd0) ? cfg.primary_type_code
                                                    : cfg.secondary_type_code;
                     end else begin
                        key_in = ty_ff;
                     end
                     state_in = S_SCAN;
                  end
               end
            endcase
         end

         S_SCAN: begin
            if (pend_ff && hit) begin
               // first match ends the scan
               pend_in  = 1'b0;
               state_in = S_RESP;
               if (cmd_ff == CMD_ENTRY) begin
                  status_in = ST_INVALID;
                  fail_in   = 1'b1;
               end else begin
                  status_in  = ST_OK;
                  fnd_ty_in  = r_ty;
                  fnd_off_in = r_off;
                  fnd_sz_in  = r_sz;
                  fnd_fl_in  = r_fl;
               end
            end else if (rd_idx_ff < acc_ff) begin
               rd_idx_in = rd_idx_ff + 1'b1;
               pend_in   = 1'b1;
            end else begin
               pend_in = 1'b0;
               if (!pend_ff) begin
                  // every stored entry checked without a match
                  state_in = S_RESP;
                  if (cmd_ff == CMD_ENTRY) begin
                     ram_we    = 1'b1;
                     acc_in    = acc_ff + 1'b1;
                     status_in = ST_OK;
                  end else begin
                     status_in = ST_INVALID;
                  end
               end
            end
         end

         S_RESP: begin
            if (rsp_chan.ready) begin
               state_in = S_IDLE;
            end
         end

         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   // control state
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= S_IDLE;
         ann_ff    <= '0;
         acc_ff    <= '0;
         hdr_ff    <= 1'b0;
         fail_ff   <= 1'b0;
         rd_idx_ff <= '0;
         pend_ff   <= 1'b0;
      end else begin
         state_ff  <= state_in;
         ann_ff    <= ann_in;
         acc_ff    <= acc_in;
         hdr_ff    <= hdr_in;
         fail_ff   <= fail_in;
         rd_idx_ff <= rd_idx_in;
         pend_ff   <= pend_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      cmd_ff     <= cmd_in;
      magic_ff   <= magic_in;
      ver_ff     <= ver_in;
      cnt_ff     <= cnt_in;
      ty_ff      <= ty_in;
      off_ff     <= off_in;
      sz_ff      <= sz_in;
      fl_ff      <= fl_in;
      slot_ff    <= slot_in;
      key_ff     <= key_in;
      end_ff     <= end_in;
      status_ff  <= status_in;
      fnd_ty_ff  <= fnd_ty_in;
      fnd_off_ff <= fnd_off_in;
      fnd_sz_ff  <= fnd_sz_in;
      fnd_fl_ff  <= fnd_fl_in;
   end

endmodule

### rtl/core/partition_table_checker_top.sv
// channel   | dir | handshake    | payload
// ----------+-----+--------------+------------------------------------------------
// req_chan  | in  | valid/ready  | command, header words, entry fields, slot_id
// rsp_chan  | out | valid/ready  | status, found_* fields, table_complete
// csr_chan  | in  | valid/ready  | index (3 bits), data (32 bits), always ready
//
// one item at a time: a header is checked in S_EVAL, its result registered;
// an entry or lookup that passes its checks then scans the N stored entries
// through the single-read-port entry memory (one entry per cycle); an entry
// or a lookup ends early on its first match
// reset is synchronous and clears the table state; entry memory needs no clearing
// req_chan is not ready while an item is in work or its result waits on rsp_chan
module partition_table_checker_top
   import ptc_pkg::*;
#(
   parameter int MAX_ENTRIES = 16
) (
   input  logic      clock,
   input  logic      reset,
   ptc_req_if.sink   req_chan,
   ptc_rsp_if.source rsp_chan,
   ptc_csr_if.sink   csr_chan
);

   localparam int IDX_W = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;

   cfg_type cfg_ff, cfg_in;

   logic               ram_we;
   logic [IDX_W-1:0]   ram_waddr;
   logic [ENTRY_W-1:0] ram_wdata;
   logic [IDX_W-1:0]   ram_raddr;
   logic [ENTRY_W-1:0] ram_rdata;

   // configuration register writes
   assign csr_chan.ready = 1'b1;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_chan.valid) begin
         unique case (csr_index_type'(csr_chan.index))
            CSR_STORAGE_BYTES:    cfg_in.storage_bytes       = csr_chan.data;
            CSR_SECTOR_SHIFT:     cfg_in.sector_shift        = csr_chan.data[4:0];
            CSR_EXPECTED_MAGIC:   cfg_in.expected_magic      = csr_chan.data;
            CSR_EXPECTED_VERSION: cfg_in.expected_version    = csr_chan.data;
            CSR_INVALID_TYPE:     cfg_in.invalid_type_code   = csr_chan.data;
            CSR_PRIMARY_TYPE:     cfg_in.primary_type_code   = csr_chan.data;
            CSR_SECONDARY_TYPE:   cfg_in.secondary_type_code = csr_chan.data;
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff <= CFG_RESET;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   // sequencer with the shared compare unit
   ptc_seq #(
      .MAX_ENTRIES (MAX_ENTRIES)
   ) u_seq (
      .clock     (clock),
      .reset     (reset),
      .cfg       (cfg_ff),
      .req_chan  (req_chan),
      .rsp_chan  (rsp_chan),
      .ram_we    (ram_we),
      .ram_waddr (ram_waddr),
      .ram_wdata (ram_wdata),
      .ram_raddr (ram_raddr),
      .ram_rdata (ram_rdata)
   );

   // stored entries: type, offset, size, flags
   ptc_ram #(
      .WIDTH (ENTRY_W),
      .DEPTH (MAX_ENTRIES)
   ) u_entries (
      .clock (clock),
      .we    (ram_we),
      .waddr (ram_waddr),
      .wdata (ram_wdata),
      .raddr (ram_raddr),
      .rdata (ram_rdata)
   );

endmodule
